FILE: rtl/go_back_n_sender_defines.svh
// ---------------------------------------------------------------------------
// go_back_n_sender_defines
// Assertion macros shared by the go-back-n sender checker.
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("go_back_n_sender: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define GBN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("go_back_n_sender: next-cycle property violated");

`endif

FILE: rtl/gbn_pkg.sv
// ---------------------------------------------------------------------------
// gbn_pkg
// Types and constants of the go-back-n sender.
// ---------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned PORT_SEQ_W = 16;
  localparam int unsigned WORD0_W   = 64;
  localparam int unsigned WORD1_W   = 64;
  localparam int unsigned WORD2_W   = 32;
  localparam int unsigned STORE_W   = WORD0_W + WORD1_W + WORD2_W;

  // Window base and next sequence number after reset.
  localparam int unsigned SEQ_RESET = 1;

  typedef enum logic [OP_W-1:0] {
    OP_MSG = 2'd0,
    OP_ACK = 2'd1,
    OP_TMO = 2'd2
  } op_e;

  // Code with no meaning, dropped without a result.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PACKET   = 3'd0,
    KIND_TSTART   = 3'd1,
    KIND_TSTOP    = 3'd2,
    KIND_TRESTART = 3'd3,
    KIND_REFUSED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESEND,
    ST_TSTART
  } state_e;

  // Where the payload of a result comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_INPUT,
    SRC_RAM
  } src_e;

  typedef struct packed {
    logic                  valid;
    kind_e                 kind;
    logic [PORT_SEQ_W-1:0] seq;
    src_e                  src;
    logic                  last;
  } emit_t;

endpackage

FILE: rtl/gbn_ram.sv
// ---------------------------------------------------------------------------
// gbn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gbn_ctrl.sv
// ---------------------------------------------------------------------------
// gbn_ctrl
// Window state, command decode and resend sequencer of the go-back-n sender.
// ---------------------------------------------------------------------------
module gbn_ctrl #(
  parameter int unsigned WINDOW     = 8,
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned SEQ_BITS   = 16,
  localparam int unsigned SlotW     = $clog2(RING_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [gbn_pkg::OP_W-1:0]      op_i,
  input  logic [gbn_pkg::PORT_SEQ_W-1:0] ack_seq_i,
  input  logic                          ack_intact_i,
  output logic                          busy,
  output gbn_pkg::emit_t                emit_o,
  output logic                          ram_we_o,
  output logic [SlotW-1:0]              ram_waddr_o,
  output logic                          ram_re_o,
  output logic [SlotW-1:0]              ram_raddr_o
);
  import gbn_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SEQ_BITS-1:0] base_q, base_d;
  logic [SEQ_BITS-1:0] next_q, next_d;
  logic [SlotW-1:0]    bslot_q, bslot_d;

  logic [SEQ_BITS-1:0] outstanding;
  logic [CntW-1:0]     inflight;
  logic                win_open;
  logic                ring_full;
  logic [SEQ_BITS-1:0] ack_a;
  logic [SEQ_BITS-1:0] ack_next;
  logic [SEQ_BITS-1:0] ack_d;

  // base_slot + off mod RING_DEPTH; off never exceeds RING_DEPTH.
  function automatic logic [SlotW-1:0] slot_at(input logic [SlotW-1:0] bslot,
                                               input logic [SlotW:0] off);
    logic [SlotW:0] sum;
    sum = {1'b0, bslot} + off;
    if (sum >= (SlotW+1)'(RING_DEPTH)) begin
      sum = sum - (SlotW+1)'(RING_DEPTH);
    end
    return sum[SlotW-1:0];
  endfunction

  assign outstanding = next_q - base_q;
  assign win_open    = 32'(outstanding) < 32'(WINDOW);
  assign inflight    = win_open ? CntW'(outstanding) : CntW'(WINDOW);
  assign ring_full   = (32'(outstanding) >= 32'(RING_DEPTH)) || (&outstanding);
  assign ack_a       = SEQ_BITS'(ack_seq_i);
  assign ack_next    = ack_a + SEQ_BITS'(1);
  assign ack_d       = ack_next - base_q;

  assign busy = (state_q != ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (op_i == OP_MSG && !ring_full && outstanding == '0) begin
            state_d = ST_TSTART;
          end else if (op_i == OP_TMO && inflight != '0) begin
            state_d = ST_RESEND;
            cnt_d   = '0;
          end
        end
      end
      ST_RESEND: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == inflight - CntW'(1)) begin
          state_d = ST_TSTART;
        end
      end
      ST_TSTART: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and result requests
  always_comb begin
    base_d      = base_q;
    next_d      = next_q;
    bslot_d     = bslot_q;
    emit_o      = '{valid: 1'b0, kind: KIND_PACKET, seq: '0, src: SRC_ZERO, last: 1'b0};
    ram_we_o    = 1'b0;
    ram_waddr_o = slot_at(bslot_q, (SlotW+1)'(outstanding));
    ram_re_o    = 1'b0;
    ram_raddr_o = slot_at(bslot_q, (SlotW+1)'(cnt_q));
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (op_i)
            OP_MSG: begin
              if (ring_full) begin
                emit_o.valid = 1'b1;
                emit_o.kind  = KIND_REFUSED;
                emit_o.last  = 1'b1;
              end else begin
                ram_we_o = 1'b1;
                next_d   = next_q + SEQ_BITS'(1);
                if (win_open) begin
                  emit_o.valid = 1'b1;
                  emit_o.kind  = KIND_PACKET;
                  emit_o.seq   = PORT_SEQ_W'(next_q);
                  emit_o.src   = SRC_INPUT;
                  // empty window: a timer start follows
                  emit_o.last  = (outstanding != '0);
                end
              end
            end
            OP_ACK: begin
              if (ack_intact_i) begin
                if (ack_d == '0) begin
                  // duplicate of the last ack
                  if (outstanding == '0) begin
                    emit_o.valid = 1'b1;
                    emit_o.kind  = KIND_TSTOP;
                    emit_o.last  = 1'b1;
                  end
                end else if (32'(ack_d) <= 32'(inflight)) begin
                  base_d       = ack_next;
                  bslot_d      = slot_at(bslot_q, (SlotW+1)'(ack_d));
                  emit_o.valid = 1'b1;
                  emit_o.kind  = (ack_next == next_q) ? KIND_TSTOP : KIND_TRESTART;
                  emit_o.last  = 1'b1;
                end
              end
            end
            OP_TMO: begin
              if (inflight == '0) begin
                emit_o.valid = 1'b1;
                emit_o.kind  = KIND_TSTART;
                emit_o.last  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RESEND: begin
        ram_re_o     = 1'b1;
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_PACKET;
        emit_o.seq   = PORT_SEQ_W'(base_q + SEQ_BITS'(cnt_q));
        emit_o.src   = SRC_RAM;
      end
      ST_TSTART: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_TSTART;
        emit_o.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      base_q  <= SEQ_BITS'(SEQ_RESET);
      next_q  <= SEQ_BITS'(SEQ_RESET);
      bslot_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      next_q  <= next_d;
      bslot_q <= bslot_d;
    end
  end

endmodule

FILE: rtl/gbn_out.sv
// ---------------------------------------------------------------------------
// gbn_out
// Result register with payload select between input, RAM and zero.
// ---------------------------------------------------------------------------
module gbn_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gbn_pkg::emit_t                  emit_i,
  input  logic [gbn_pkg::STORE_W-1:0]     in_word_i,
  input  logic [gbn_pkg::STORE_W-1:0]     ram_rdata_i,
  output logic                            valid_o,
  output logic [gbn_pkg::KIND_W-1:0]      kind_o,
  output logic [gbn_pkg::PORT_SEQ_W-1:0]  out_seq_o,
  output logic [gbn_pkg::WORD0_W-1:0]     out_word0_o,
  output logic [gbn_pkg::WORD1_W-1:0]     out_word1_o,
  output logic [gbn_pkg::WORD2_W-1:0]     out_word2_o,
  output logic                            last_o
);
  import gbn_pkg::*;

  logic                  valid_q;
  kind_e                 kind_q;
  logic [PORT_SEQ_W-1:0] seq_q;
  src_e                  src_q;
  logic                  last_q;
  logic [STORE_W-1:0]    word_q;
  logic [STORE_W-1:0]    word_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      kind_q <= emit_i.kind;
      seq_q  <= emit_i.seq;
      src_q  <= emit_i.src;
      last_q <= emit_i.last;
      if (emit_i.src == SRC_INPUT) begin
        word_q <= in_word_i;
      end
    end
  end

  always_comb begin
    unique case (src_q)
      SRC_INPUT: word_sel = word_q;
      SRC_RAM:   word_sel = ram_rdata_i;
      default:   word_sel = '0;
    endcase
  end

  assign valid_o     = valid_q;
  assign kind_o      = kind_q;
  assign out_seq_o   = seq_q;
  assign last_o      = last_q;
  assign out_word0_o = word_sel[WORD0_W-1:0];
  assign out_word1_o = word_sel[WORD0_W+WORD1_W-1:WORD0_W];
  assign out_word2_o = word_sel[STORE_W-1:WORD0_W+WORD1_W];

endmodule

FILE: rtl/go_back_n_sender.sv
// ---------------------------------------------------------------------------
// go_back_n_sender
// Go-back-N ARQ sender: ring buffer of messages, send window, timer requests.
// ---------------------------------------------------------------------------
// Command channel: a transfer happens on a rising edge with start high and
//   busy low; op selects message, acknowledgement or timeout.
// Result channel: each result sits on the output ports for one cycle with
//   valid_o high; last_o marks the final result of a command. The receiver
//   cannot stall, so results are never held.
// Messages, acks, and timeouts with nothing in flight: any result in the cycle
//   after the transfer, busy stays low, so one command per cycle. A message
//   that opens an empty window adds a timer start and holds busy one cycle.
// Timeout with n packets in flight (n <= WINDOW): busy through resend and
//   timer start; the packets come one per cycle from the payload RAM over
//   its single read port, the first once resend is entered, then a timer start.
// Reset: window base and next sequence number return to 1, the ring is
//   empty. The payload RAM is not cleared; only written entries are read.
// ---------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int unsigned WINDOW     = 8,
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned SEQ_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [gbn_pkg::OP_W-1:0]        op_i,
  input  logic [gbn_pkg::WORD0_W-1:0]     payload_word0_i,
  input  logic [gbn_pkg::WORD1_W-1:0]     payload_word1_i,
  input  logic [gbn_pkg::WORD2_W-1:0]     payload_word2_i,
  input  logic [gbn_pkg::PORT_SEQ_W-1:0]  ack_seq_i,
  input  logic                            ack_intact_i,
  output logic                            valid_o,
  output logic [gbn_pkg::KIND_W-1:0]      kind_o,
  output logic [gbn_pkg::PORT_SEQ_W-1:0]  out_seq_o,
  output logic [gbn_pkg::WORD0_W-1:0]     out_word0_o,
  output logic [gbn_pkg::WORD1_W-1:0]     out_word1_o,
  output logic [gbn_pkg::WORD2_W-1:0]     out_word2_o,
  output logic                            last_o
);
  import gbn_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_DEPTH);

  emit_t              emit;
  logic               ram_we;
  logic [SlotW-1:0]   ram_waddr;
  logic               ram_re;
  logic [SlotW-1:0]   ram_raddr;
  logic [STORE_W-1:0] in_word;
  logic [STORE_W-1:0] ram_rdata;

  // Payload packed as one RAM word: word2 on top, word0 at the bottom.
  assign in_word = {payload_word2_i, payload_word1_i, payload_word0_i};

  // Window state and sequencing. Writes happen only on message transfers
  // and reads only while resending with busy high, so the two never meet
  // on the same entry in one cycle.
  gbn_ctrl #(
    .WINDOW     (WINDOW),
    .RING_DEPTH (RING_DEPTH),
    .SEQ_BITS   (SEQ_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .op_i         (op_i),
    .ack_seq_i    (ack_seq_i),
    .ack_intact_i (ack_intact_i),
    .busy         (busy),
    .emit_o       (emit),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  // Ring of stored payloads, one entry per outstanding message.
  gbn_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register; RAM read data lines up with it in the cycle after issue.
  gbn_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .in_word_i   (in_word),
    .ram_rdata_i (ram_rdata),
    .valid_o     (valid_o),
    .kind_o      (kind_o),
    .out_seq_o   (out_seq_o),
    .out_word0_o (out_word0_o),
    .out_word1_o (out_word1_o),
    .out_word2_o (out_word2_o),
    .last_o      (last_o)
  );

endmodule

FILE: rtl/gbn_checker.sv
// ---------------------------------------------------------------------------
// gbn_checker
// Port-level assertions for the go-back-n sender, bound to the top level.
// ---------------------------------------------------------------------------
`include "go_back_n_sender_defines.svh"

module gbn_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [gbn_pkg::OP_W-1:0]        op_i,
  input logic                            valid_o,
  input logic [gbn_pkg::KIND_W-1:0]      kind_o,
  input logic                            last_o
);
  import gbn_pkg::*;

  // Results of one command form an unbroken train.
  `GBN_ASSERT_NXT(a_train_gapless, clk_i, rst_ni, valid_o && !last_o, valid_o)

  // No new command is taken before the train ends.
  `GBN_ASSERT_IMP(a_train_busy, clk_i, rst_ni, valid_o && !last_o, busy)

  // Timer start and refusal always close a command.
  `GBN_ASSERT_IMP(a_tail_last, clk_i, rst_ni, valid_o && (kind_o == KIND_TSTART || kind_o == KIND_REFUSED), last_o)

  // Reserved op code yields nothing.
  `GBN_ASSERT_NXT(a_reserved_silent, clk_i, rst_ni, start && !busy && op_i == OP_RESERVED, !valid_o)

endmodule

bind go_back_n_sender gbn_checker u_checker (.*);
